@@ rtl/mkbgd_pkg.sv @@
// ----------------------------------------------------------------------------
// mkbgd_pkg - shared types and constants for the key gesture detector
// Key record layout, event and opcode codes, register indexes and defaults.
// ----------------------------------------------------------------------------
package mkbgd_pkg;

  // Key store geometry
  localparam int KEYS  = 8;
  localparam int KEY_W = $clog2(KEYS);
  localparam int CNT_W = $clog2(KEYS + 1);

  // Field widths
  localparam int DEB_W  = 10;
  localparam int DCK_W  = 12;
  localparam int LNG_W  = 13;
  localparam int KCNT_W = 4;
  localparam int CFG_W  = 13;
  localparam int CIDX_W = 2;

  // Results per input word are capped at this count
  localparam int MAX_RES = 16;
  localparam int RCNT_W  = $clog2(MAX_RES + 1);

  // Saturation value of the elapsed counters
  localparam logic [DEB_W-1:0] SINCE_MAX = '1;

  // Input opcodes
  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_DCLICK   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LONG     = 2'd2;
  localparam logic [CIDX_W-1:0] REG_KCOUNT   = 2'd3;

  // Register defaults
  localparam logic [DEB_W-1:0]  DEF_DEBOUNCE = 10'd30;
  localparam logic [DCK_W-1:0]  DEF_DCLICK   = 12'd350;
  localparam logic [LNG_W-1:0]  DEF_LONG     = 13'd900;
  localparam logic [KCNT_W-1:0] DEF_KCOUNT   = 4'd8;

  // Gesture events
  typedef enum logic [2:0] {
    EV_DOWN         = 3'd0,
    EV_UP           = 3'd1,
    EV_LONG_PRESS   = 3'd2,
    EV_LONG_RELEASE = 3'd3,
    EV_CLICK        = 3'd4,
    EV_DOUBLE       = 3'd5
  } ev_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MOD,
    ST_EMIT,
    ST_FIN
  } state_t;

  // One key's record as held in the store
  typedef struct packed {
    logic             held;
    logic             long_done;
    logic [DEB_W-1:0] since_press;
    logic [DEB_W-1:0] since_release;
    logic             released_once;
    logic [LNG_W-1:0] long_left;
    logic             long_armed;
    logic [DCK_W-1:0] click_left;
    logic             click_armed;
    logic [1:0]       clicks;
  } key_rec_t;

endpackage

@@ rtl/multi_key_button_gesture_detector_unit.sv @@
// ----------------------------------------------------------------------------
// multi_key_button_gesture_detector_unit - per-key click and hold classifier
// Debounces press and release edges and turns them, together with a
// millisecond tick, into down, up, long, click and double click events.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake           payload
//  in       in   in_valid/in_stall   in_opcode, in_key
//  out      out  out_valid/out_stall out_event_res, out_event_key, out_last
//  cfg      in   cfg_we              cfg_index, cfg_wdata
//
// Key records live in a one-port-write, one-port-read store with registered
// read data. Each visited key passes through read, modify and one emit step
// per event plus one. An edge visits its one key and a tick visits every key
// in use; the input stalls from the word's acceptance until the sequencer is
// back in idle, where the next word is taken. The read-modify-write of one
// record ends before the next read starts. Reset clears the per-key valid
// bits at once; no clearing pass.
// A stalled result holds the sequencer only when a second result is ready.
//
module multi_key_button_gesture_detector_unit
  import mkbgd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [2:0]        in_key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_event_res,
  output logic [2:0]        out_event_key,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  // Configuration
  logic [DEB_W-1:0]  debounce_r;
  logic [DCK_W-1:0]  dclick_r;
  logic [LNG_W-1:0]  long_r;
  logic [KCNT_W-1:0] kcount_r;

  // Sequencer
  state_t            state_r, state_nxt;
  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]  act_keys;
  logic [CNT_W-1:0]  key_next;
  logic              more_keys;
  logic              in_acc;
  logic              start;

  // Key store
  key_rec_t          mem [KEYS];
  logic [KEYS-1:0]   vld_r;
  key_rec_t          rd_data_r;
  logic              rd_vld_r;
  key_rec_t          rec, rec_nxt;

  // Events of the current key
  ev_t               ev_r [2];
  logic [1:0]        ev_n_r;
  logic [1:0]        ev_i_r;
  ev_t               ev0, ev1;
  logic              ev0_v, ev1_v;

  // Result path
  logic [RCNT_W-1:0] emit_cnt_r;
  logic              pend_v_r;
  ev_t               pend_ev_r;
  logic [KEY_W-1:0]  pend_key_r;
  logic              out_valid_r;
  ev_t               out_ev_r;
  logic [KEY_W-1:0]  out_key_r;
  logic              out_last_r;

  // Strobes
  logic              can_push;
  logic              ev_pending;
  logic              drop;
  logic              push_go;
  logic              out_ld;
  logic              mem_we;

  // Keys in use and the key after the current one
  assign act_keys  = (CNT_W'(kcount_r) < CNT_W'(KEYS)) ? CNT_W'(kcount_r) : CNT_W'(KEYS);
  assign key_next  = CNT_W'(key_r) + CNT_W'(1);
  assign more_keys = (op_r == OP_TICK) && (key_next < act_keys);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Decide whether an accepted word has any key to visit
  always_comb begin
    unique case (in_opcode)
      OP_TICK:             start = (act_keys != '0);
      OP_PRESS, OP_RELEASE: start = (CNT_W'(in_key) < act_keys);
      default:             start = 1'b0;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEF_DEBOUNCE;
      dclick_r   <= DEF_DCLICK;
      long_r     <= DEF_LONG;
      kcount_r   <= DEF_KCOUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_r <= cfg_wdata[DEB_W-1:0];
        REG_DCLICK:   dclick_r   <= cfg_wdata[DCK_W-1:0];
        REG_LONG:     long_r     <= cfg_wdata[LNG_W-1:0];
        REG_KCOUNT:   kcount_r   <= cfg_wdata[KCNT_W-1:0];
        default:      ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && start) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!ev_pending) state_nxt = more_keys ? ST_READ : ST_FIN;
      end
      ST_FIN:  if (!pend_v_r || can_push) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    can_push   = !out_valid_r || !out_stall;
    ev_pending = (ev_i_r < ev_n_r);
    drop       = (emit_cnt_r == RCNT_W'(MAX_RES));
    mem_we     = 1'b0;
    push_go    = 1'b0;
    out_ld     = 1'b0;
    unique case (state_r)
      ST_MOD:  mem_we = 1'b1;
      ST_EMIT: begin
        push_go = ev_pending && (drop || !pend_v_r || can_push);
        out_ld  = push_go && !drop && pend_v_r;
      end
      ST_FIN:  out_ld = pend_v_r && can_push;
      default: ;
    endcase
  end

  // Modify one key record
  assign rec = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    logic noise;
    logic lp_fire;
    logic ck_fire;
    ev_t  ck_ev;
    rec_nxt = rec;
    ev0     = EV_DOWN;
    ev1     = EV_DOWN;
    ev0_v   = 1'b0;
    ev1_v   = 1'b0;
    noise   = 1'b0;
    lp_fire = 1'b0;
    ck_fire = 1'b0;
    ck_ev   = EV_CLICK;
    unique case (op_r)
      OP_PRESS: begin
        if (!rec.held && !(rec.released_once && rec.since_release < debounce_r)) begin
          rec_nxt.held        = 1'b1;
          rec_nxt.long_done   = 1'b0;
          rec_nxt.since_press = '0;
          rec_nxt.long_left   = long_r;
          rec_nxt.long_armed  = 1'b1;
          ev0                 = EV_DOWN;
          ev0_v               = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (rec.held) begin
          noise                 = rec.since_press < debounce_r;
          rec_nxt.held          = 1'b0;
          rec_nxt.since_release = '0;
          rec_nxt.released_once = 1'b1;
          rec_nxt.long_armed    = 1'b0;
          ev0                   = EV_UP;
          ev1                   = EV_LONG_RELEASE;
          ev0_v                 = !noise;
          ev1_v                 = !noise && rec.long_done;
          if (!noise) begin
            if (rec.long_done) begin
              rec_nxt.clicks      = 2'd0;
              rec_nxt.click_armed = 1'b0;
            end else begin
              if (rec.clicks != 2'd3) rec_nxt.clicks = rec.clicks + 2'd1;
              rec_nxt.click_left  = dclick_r;
              rec_nxt.click_armed = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        // advance elapsed counters, saturating
        if (rec.since_press != SINCE_MAX) rec_nxt.since_press = rec.since_press + DEB_W'(1);
        if (rec.since_release != SINCE_MAX) begin
          rec_nxt.since_release = rec.since_release + DEB_W'(1);
        end
        // long timer goes first
        if (rec.long_armed) begin
          if (rec.long_left <= LNG_W'(1)) begin
            rec_nxt.long_left  = '0;
            rec_nxt.long_armed = 1'b0;
            if (rec.held && !rec.long_done) begin
              rec_nxt.long_done = 1'b1;
              lp_fire           = 1'b1;
            end
          end else begin
            rec_nxt.long_left = rec.long_left - LNG_W'(1);
          end
        end
        // then the click window
        if (rec.click_armed) begin
          if (rec.click_left <= DCK_W'(1)) begin
            rec_nxt.click_left  = '0;
            rec_nxt.click_armed = 1'b0;
            rec_nxt.clicks      = 2'd0;
            ck_fire             = (rec.clicks != 2'd0);
            ck_ev               = (rec.clicks == 2'd1) ? EV_CLICK : EV_DOUBLE;
          end else begin
            rec_nxt.click_left = rec.click_left - DCK_W'(1);
          end
        end
        ev0   = lp_fire ? EV_LONG_PRESS : ck_ev;
        ev0_v = lp_fire || ck_fire;
        ev1   = ck_ev;
        ev1_v = lp_fire && ck_fire;
      end
      default: ;
    endcase
  end

  // Key store: registered read, write back in the modify cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[key_r];
    if (mem_we) mem[key_r] <= rec_nxt;
  end

  // Valid bits: a never-written record reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[key_r];
      if (mem_we) vld_r[key_r] <= 1'b1;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ev_n_r     <= 2'd0;
      ev_i_r     <= 2'd0;
      emit_cnt_r <= '0;
      pend_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) emit_cnt_r <= '0;
      // latch this key's events
      if (mem_we) begin
        ev_i_r <= 2'd0;
        ev_n_r <= 2'(ev0_v) + 2'(ev1_v);
      end
      // advance through events; a capped word drops the rest
      if (push_go) begin
        ev_i_r <= ev_i_r + 2'd1;
        if (!drop) begin
          pend_v_r   <= 1'b1;
          emit_cnt_r <= emit_cnt_r + RCNT_W'(1);
        end
      end
      if (out_ld && state_r == ST_FIN) pend_v_r <= 1'b0;
      // hold the result word until taken
      if (out_ld) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_opcode;
      key_r <= (in_opcode == OP_TICK) ? '0 : KEY_W'(in_key);
    end else if (state_r == ST_EMIT && !ev_pending && more_keys) begin
      key_r <= key_next[KEY_W-1:0];
    end
    if (mem_we) begin
      ev_r[0] <= ev0;
      ev_r[1] <= ev1;
    end
    if (push_go && !drop) begin
      pend_ev_r  <= ev_r[ev_i_r[0]];
      pend_key_r <= key_r;
    end
    if (out_ld) begin
      out_ev_r   <= pend_ev_r;
      out_key_r  <= pend_key_r;
      out_last_r <= (state_r == ST_FIN);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_ev_r;
  assign out_event_key = 3'(out_key_r);
  assign out_last      = out_last_r;

  // Checks
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_v_r)
    else $error("held result left behind at end of word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld && out_valid_r |-> !out_stall)
    else $error("result register loaded while stalled");

  a_key_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> CNT_W'(key_r) < act_keys)
    else $error("visit of a key not in use");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    emit_cnt_r <= RCNT_W'(MAX_RES) && ev_n_r <= 2'd2)
    else $error("result count out of range");

endmodule

@@ tb/tb_multi_key_button_gesture_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_key_button_gesture_detector_unit - gesture detector testbench
// Sends press, release and tick words in random bursts, predicts the gesture
// events with a local per-key model and checks every event word in order
// while the output side stalls at random and twice for a long stretch.
// ----------------------------------------------------------------------------
module tb_multi_key_button_gesture_detector_unit;
  import mkbgd_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         SETTLE_CYCLES = 64;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         RANDOM_WORDS  = 350;

  typedef struct packed {
    ev_t        ev;
    logic [2:0] key;
    logic       last;
  } gesture_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode = OP_TICK;
  logic [2:0]        in_key    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_event_res;
  logic [2:0]        out_event_key;
  logic              out_last;
  logic              cfg_we    = 1'b0;
  logic [CIDX_W-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  // Per-key gesture model
  logic             key_down      [KEYS];
  logic             lp_reported   [KEYS];
  logic [DEB_W-1:0] ms_since_down [KEYS];
  logic [DEB_W-1:0] ms_since_up   [KEYS];
  logic             seen_release  [KEYS];
  logic [LNG_W-1:0] long_cnt      [KEYS];
  logic             long_run      [KEYS];
  logic [DCK_W-1:0] click_cnt     [KEYS];
  logic             click_run     [KEYS];
  logic [1:0]       click_tally   [KEYS];

  // Register copies
  logic [DEB_W-1:0]  deb_ms;
  logic [DCK_W-1:0]  dclick_ms;
  logic [LNG_W-1:0]  long_ms;
  logic [KCNT_W-1:0] key_lim;

  gesture_t    event_q[$];
  gesture_t    step_events[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_cnt   = 0;
  int          burst_left  = 0;
  bit          rx_hold_req = 1'b0;

  multi_key_button_gesture_detector_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .out_event_key (out_event_key),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  function automatic int live_keys();
    return (key_lim < KEYS) ? int'(key_lim) : KEYS;
  endfunction

  // Queue one event of the current word; drop anything past the cap
  function automatic void note_event(input ev_t ev, input int k);
    gesture_t g;
    g.ev   = ev;
    g.key  = 3'(k);
    g.last = 1'b0;
    if (step_events.size() < MAX_RES) step_events.push_back(g);
  endfunction

  // Advance the key model by one accepted word and queue its events
  function automatic void predict_word(input logic [1:0] op, input logic [2:0] k);
    gesture_t g;
    logic     noise;
    step_events.delete();
    case (op)
      OP_TICK: begin
        for (int i = 0; i < live_keys(); i++) begin
          if (ms_since_down[i] != SINCE_MAX) ms_since_down[i]++;
          if (ms_since_up[i] != SINCE_MAX) ms_since_up[i]++;
          // long timer first, then the click window
          if (long_run[i]) begin
            if (long_cnt[i] <= 13'd1) begin
              long_cnt[i] = '0;
              long_run[i] = 1'b0;
              if (key_down[i] && !lp_reported[i]) begin
                lp_reported[i] = 1'b1;
                note_event(EV_LONG_PRESS, i);
              end
            end else begin
              long_cnt[i]--;
            end
          end
          if (click_run[i]) begin
            if (click_cnt[i] <= 12'd1) begin
              click_cnt[i] = '0;
              click_run[i] = 1'b0;
              if (click_tally[i] == 2'd1) note_event(EV_CLICK, i);
              else if (click_tally[i] >= 2'd2) note_event(EV_DOUBLE, i);
              click_tally[i] = '0;
            end else begin
              click_cnt[i]--;
            end
          end
        end
      end
      OP_PRESS: if (k < live_keys() && !key_down[k] &&
                    !(seen_release[k] && ms_since_up[k] < deb_ms)) begin
        key_down[k]      = 1'b1;
        lp_reported[k]   = 1'b0;
        ms_since_down[k] = '0;
        note_event(EV_DOWN, k);
        long_cnt[k] = long_ms;
        long_run[k] = 1'b1;
      end
      OP_RELEASE: if (k < live_keys() && key_down[k]) begin
        noise           = ms_since_down[k] < deb_ms;
        key_down[k]     = 1'b0;
        ms_since_up[k]  = '0;
        seen_release[k] = 1'b1;
        long_run[k]     = 1'b0;
        if (!noise) begin
          note_event(EV_UP, k);
          if (lp_reported[k]) begin
            note_event(EV_LONG_RELEASE, k);
            click_tally[k] = '0;
            click_run[k]   = 1'b0;
          end else begin
            if (click_tally[k] != 2'd3) click_tally[k]++;
            click_cnt[k] = dclick_ms;
            click_run[k] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    foreach (step_events[i]) begin
      g      = step_events[i];
      g.last = (i == step_events.size() - 1);
      event_q.push_back(g);
    end
  endfunction

  // Offer one word in the current burst; open a new burst after a gap
  task automatic send_word(input logic [1:0] op, input logic [2:0] k);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_key    <= k;
    do @(posedge clk); while (in_stall);
    predict_word(op, k);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // Drop valid, wait for all events, then let the block go quiet
  task automatic settle();
    if (burst_left != 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
    while (event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input int deb, input int dck, input int lng, input int kc);
    settle();
    write_reg(REG_DEBOUNCE, CFG_W'(deb));
    write_reg(REG_DCLICK, CFG_W'(dck));
    write_reg(REG_LONG, CFG_W'(lng));
    write_reg(REG_KCOUNT, CFG_W'(kc));
    cfg_we    <= 1'b0;
    deb_ms    = DEB_W'(deb);
    dclick_ms = DCK_W'(dck);
    long_ms   = LNG_W'(lng);
    key_lim   = KCNT_W'(kc);
  endtask

  // Reset settings: held-key press, short press, gap debounce, dead words
  task automatic test_defaults();
    send_word(OP_PRESS, 3'd7);
    send_word(OP_PRESS, 3'd7);
    send_word(OP_RELEASE, 3'd7);
    send_word(OP_PRESS, 3'd7);
    send_word(OP_RELEASE, 3'd0);
    send_word(OP_UNUSED, 3'd5);
    send_word(OP_TICK, 3'd3);
  endtask

  // Two live keys: edges above the limit vanish, long press on one tick
  task automatic test_narrow_keys();
    set_config(1, 2, 1, 2);
    send_word(OP_PRESS, 3'd0);
    send_word(OP_PRESS, 3'd5);
    send_word(OP_RELEASE, 3'd6);
    send_word(OP_TICK, 3'd2);
    send_word(OP_RELEASE, 3'd0);
  endtask

  // No live keys at all
  task automatic test_no_keys();
    set_config(30, 350, 900, 0);
    send_word(OP_PRESS, 3'd0);
    send_word(OP_TICK, 3'd0);
  endtask

  // Zero timers: click count saturation, long before click on one key
  task automatic test_zero_timers();
    set_config(0, 0, 0, 8);
    repeat (4) begin
      send_word(OP_PRESS, 3'd0);
      send_word(OP_RELEASE, 3'd0);
    end
    send_word(OP_PRESS, 3'd7);
    send_word(OP_RELEASE, 3'd7);
    send_word(OP_PRESS, 3'd7);
    send_word(OP_TICK, 3'd1);
    send_word(OP_RELEASE, 3'd7);
  endtask

  // Every key fires long and click on one tick while the output holds off
  task automatic test_full_tick();
    set_config(0, 0, 0, 8);
    rx_hold_req = 1'b1;
    for (int k = 0; k < KEYS; k++) begin
      send_word(OP_PRESS, 3'(k));
      send_word(OP_RELEASE, 3'(k));
      send_word(OP_PRESS, 3'(k));
    end
    send_word(OP_TICK, 3'd4);
    for (int k = 0; k < KEYS; k++) send_word(OP_RELEASE, 3'(k));
  endtask

  // Random gestures over several settings, with some noise mixed in
  task automatic test_random();
    int done_words;
    int pick;
    int k;
    int run;
    done_words = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(1, 4, 6, 8);
        1: set_config(1023, 4095, 8191, 15);
        2: set_config(0, 0, 0, 1);
        3: set_config(2, 9, 3, 3);
        default: set_config($urandom_range(0, 4), $urandom_range(0, 12),
                            $urandom_range(0, 16), $urandom_range(1, 8));
      endcase
      if (ph == 5) rx_hold_req = 1'b1;
      while (done_words < (ph + 1) * RANDOM_WORDS / 8) begin
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, live_keys() - 1);
        if (pick < 45) begin
          run = $urandom_range(1, 8);
          repeat (run) send_word(OP_TICK, 3'($urandom_range(0, 7)));
          done_words += run;
        end else if (pick < 90) begin
          send_word(key_down[k] ? OP_RELEASE : OP_PRESS, 3'(k));
          done_words++;
        end else begin
          case ($urandom_range(0, 2))
            0: send_word(OP_UNUSED, 3'($urandom_range(0, 7)));
            1: if (live_keys() < KEYS) begin
              send_word(($urandom_range(0, 1) != 0) ? OP_RELEASE : OP_PRESS,
                        3'($urandom_range(live_keys(), KEYS - 1)));
            end else begin
              send_word(OP_UNUSED, 3'($urandom_range(0, 7)));
            end
            default: send_word(key_down[k] ? OP_PRESS : OP_RELEASE, 3'(k));
          endcase
        end
      end
    end
  endtask

  // Output stall: random patterns, plus one long hold when asked
  initial begin : rx_pattern
    int mode;
    int mode_left;
    int hold_left;
    int phase;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && hold_left == 0) begin
        hold_left   = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (phase % 5 < 2);
        endcase
      end
    end
  end

  // Compare each accepted event word with the oldest prediction
  always @(posedge clk) begin : event_check
    gesture_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (event_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event word: res %0d key %0d last %0b",
                   out_event_res, out_event_key, out_last);
      end else begin
        want = event_q.pop_front();
        if (want.ev != out_event_res || want.key != out_event_key ||
            want.last != out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"event word differs: expected res %0d key %0d last %0b, ",
                      "got res %0d key %0d last %0b"},
                     want.ev, want.key, want.last, out_event_res, out_event_key, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("multi_key_button_gesture_detector_unit: mismatch");
      $finish;
    end
  end

  initial begin : run_tests
    deb_ms    = DEF_DEBOUNCE;
    dclick_ms = DEF_DCLICK;
    long_ms   = DEF_LONG;
    key_lim   = DEF_KCOUNT;
    for (int k = 0; k < KEYS; k++) begin
      key_down[k]      = 1'b0;
      lp_reported[k]   = 1'b0;
      ms_since_down[k] = '0;
      ms_since_up[k]   = '0;
      seen_release[k]  = 1'b0;
      long_cnt[k]      = '0;
      long_run[k]      = 1'b0;
      click_cnt[k]     = '0;
      click_run[k]     = 1'b0;
      click_tally[k]   = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_narrow_keys();
    test_no_keys();
    test_zero_timers();
    test_full_tick();
    test_random();
    settle();
    if (mismatches == 0) begin
      $display("multi_key_button_gesture_detector_unit: match");
    end else begin
      $display("multi_key_button_gesture_detector_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mkbgd_pkg.sv
rtl/multi_key_button_gesture_detector_unit.sv
tb/tb_multi_key_button_gesture_detector_unit.sv
